// ----- src/ffsa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffsa_pkg: shared types and constants for the first-fit segment allocator
// Request/response word layouts, status and action codes, sequencer states.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int HEAP_BYTES_DEF   = 32768;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int MAX_SEGMENTS_DEF = 64;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  typedef struct packed {
    logic        action;
    logic [15:0] request_bytes;
    logic [15:0] free_address;
  } ffsa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] payload_address;
  } ffsa_out_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FREE_SET,
    S_COPY_RD,
    S_COPY_WR,
    S_WR_A,
    S_WR_B,
    S_RESP
  } ffsa_state_t;

endpackage

// ----- src/ffsa_ram.sv -----
// ----------------------------------------------------------------------------
// ffsa_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/first_fit_segment_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top: first-fit heap allocator with coalescing
// Segment table in RAM, scanned and shifted by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request word (valid/ready). action selects allocate or free.
//   out_* : one response word per request (status, payload address).
//   The block handles one request at a time; in_ready is high only while
//   the sequencer is idle. The response sits in an output register, so a
//   stalled receiver does not stop the next request from being taken; that
//   request's response waits until the register frees up.
//   Per request, the sequencer scans the table from entry 0 up to the matching
//   segment (one RAM read and one check per entry); when a split or a merge
//   shifts the table, it moves each entry above the match with a read and a
//   write; then come the final table writes and the reply. A miss scans all
//   live entries before it replies. The scan and the shifts are serial, as
//   the RAM has a single port pair. The sequencer returns to idle, raising
//   in_ready, as the reply is loaded.
//   Reset: one cycle after rst_n rises the table is seeded with a single
//   free segment spanning the heap; in_ready stays low during that cycle.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_top
  import ffsa_pkg::*;
#(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ffsa_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ffsa_out_t out_data
);

  localparam int SW = $clog2(HEAP_BYTES);
  localparam int CW = ((SW > 16) ? SW : 16) + 1;
  localparam int AW = $clog2(HEAP_BYTES + HEADER_BYTES + 1);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int NW = $clog2(MAX_SEGMENTS + 1);
  localparam int DW = SW + 1;
  localparam logic [SW-1:0] HDR   = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] SIZE0 = SW'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [NW-1:0] MAXN  = NW'(MAX_SEGMENTS);

  ffsa_state_t state_r, state_nxt;

  logic          act_r, act_nxt;
  logic [15:0]   req_r, req_nxt;
  logic [15:0]   where_r, where_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic [NW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [SW-1:0] prev_size_r, prev_size_nxt;
  logic          prev_used_r, prev_used_nxt;
  logic [NW-1:0] hit_idx_r, hit_idx_nxt;
  logic [SW-1:0] cur_size_r, cur_size_nxt;
  logic          nxt_ok_r, nxt_ok_nxt;
  logic [NW-1:0] src_r, src_nxt;
  logic [NW-1:0] dst_r, dst_nxt;
  logic [NW-1:0] left_r, left_nxt;
  logic          up_r, up_nxt;
  logic [NW-1:0] wa_idx_r, wa_idx_nxt;
  logic [DW-1:0] wa_data_r, wa_data_nxt;
  logic [NW-1:0] wb_idx_r, wb_idx_nxt;
  logic [DW-1:0] wb_data_r, wb_data_nxt;
  logic          two_wr_r, two_wr_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [15:0]   res_addr_r, res_addr_nxt;
  logic          out_valid_r, out_valid_nxt;
  ffsa_out_t     out_data_r, out_data_nxt;

  // table RAM: {used, size}
  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] wr_data, rd_data;

  ffsa_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_SEGMENTS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  logic          rd_used;
  logic [SW-1:0] rd_size;
  logic [CW-1:0] size_c, req_c, hdr_c;
  logic [AW+15:0] addr_ext;
  logic [15:0]   addr16;
  logic          alloc_hit, free_hit, n_free, p_free;
  logic [SW-1:0] merged;
  logic [NW-1:0] shift_k, cp_src;

  assign rd_used  = rd_data[SW];
  assign rd_size  = rd_data[SW-1:0];
  assign size_c   = CW'(rd_size);
  assign req_c    = CW'(req_r);
  assign hdr_c    = CW'(HDR);
  assign addr_ext = {16'd0, addr_r};
  assign addr16   = addr_ext[15:0];

  // addr_r already includes this entry's header
  assign alloc_hit = !rd_used && (size_c >= req_c);
  assign free_hit  = rd_used && (addr16 == where_r);

  // merge bookkeeping, evaluated with the successor entry on rd_data
  assign n_free  = nxt_ok_r && !rd_used;
  assign p_free  = !prev_used_r;
  assign merged  = (p_free ? (prev_size_r + HDR) : '0) + cur_size_r +
                   (n_free ? (rd_size + HDR) : '0);
  assign shift_k = NW'(p_free) + NW'(n_free);
  assign cp_src  = hit_idx_r + NW'(1) + NW'(n_free);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= NW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    req_r       <= req_nxt;
    where_r     <= where_nxt;
    idx_r       <= idx_nxt;
    addr_r      <= addr_nxt;
    prev_size_r <= prev_size_nxt;
    prev_used_r <= prev_used_nxt;
    hit_idx_r   <= hit_idx_nxt;
    cur_size_r  <= cur_size_nxt;
    nxt_ok_r    <= nxt_ok_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    left_r      <= left_nxt;
    up_r        <= up_nxt;
    wa_idx_r    <= wa_idx_nxt;
    wa_data_r   <= wa_data_nxt;
    wb_idx_r    <= wb_idx_nxt;
    wb_data_r   <= wb_data_nxt;
    two_wr_r    <= two_wr_nxt;
    stat_r      <= stat_nxt;
    res_addr_r  <= res_addr_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    req_nxt       = req_r;
    where_nxt     = where_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    addr_nxt      = addr_r;
    prev_size_nxt = prev_size_r;
    prev_used_nxt = prev_used_r;
    hit_idx_nxt   = hit_idx_r;
    cur_size_nxt  = cur_size_r;
    nxt_ok_nxt    = nxt_ok_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    left_nxt      = left_r;
    up_nxt        = up_r;
    wa_idx_nxt    = wa_idx_r;
    wa_data_nxt   = wa_data_r;
    wb_idx_nxt    = wb_idx_r;
    wb_data_nxt   = wb_data_r;
    two_wr_nxt    = two_wr_r;
    stat_nxt      = stat_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = idx_r[IW-1:0];

    unique case (state_r)
      S_INIT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = {1'b0, SIZE0};
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          act_nxt       = in_data.action;
          req_nxt       = in_data.request_bytes;
          where_nxt     = in_data.free_address;
          idx_nxt       = '0;
          addr_nxt      = AW'(HDR);
          prev_used_nxt = 1'b1;
          res_addr_nxt  = '0;
          if (in_data.action == ACT_ALLOC && in_data.request_bytes == 16'd0) begin
            stat_nxt  = ST_NO_SPACE;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end

      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          stat_nxt  = (act_r == ACT_FREE) ? ST_BAD_FREE : ST_NO_SPACE;
          state_nxt = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_r[IW-1:0];
          state_nxt = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        hit_idx_nxt  = idx_r;
        cur_size_nxt = rd_size;
        if (act_r == ACT_ALLOC && alloc_hit) begin
          state_nxt = S_RESP;
          if (size_c == req_c) begin
            // exact fit: mark the whole segment used
            wr_en        = 1'b1;
            wr_addr      = idx_r[IW-1:0];
            wr_data      = {1'b1, rd_size};
            stat_nxt     = ST_OK;
            res_addr_nxt = addr16;
          end else if (size_c >= req_c + hdr_c) begin
            if (count_r == MAXN) begin
              stat_nxt = ST_NO_SPACE;
            end else begin
              // split: open a slot after idx by shifting the tail up
              src_nxt      = count_r - NW'(1);
              dst_nxt      = count_r;
              left_nxt     = count_r - idx_r - NW'(1);
              up_nxt       = 1'b1;
              wa_idx_nxt   = idx_r + NW'(1);
              wa_data_nxt  = {1'b0, SW'(size_c - req_c - hdr_c)};
              wb_idx_nxt   = idx_r;
              wb_data_nxt  = {1'b1, SW'(req_r)};
              two_wr_nxt   = 1'b1;
              count_nxt    = count_r + NW'(1);
              stat_nxt     = ST_OK;
              res_addr_nxt = addr16;
              state_nxt    = S_COPY_RD;
            end
          end else begin
            stat_nxt = ST_NO_SPACE;
          end
        end else if (act_r == ACT_FREE && free_hit) begin
          // fetch the successor for coalescing
          rd_en      = 1'b1;
          rd_addr    = IW'(idx_r + NW'(1));
          nxt_ok_nxt = (idx_r + NW'(1)) != count_r;
          state_nxt  = S_FREE_SET;
        end else begin
          addr_nxt      = addr_r + AW'(rd_size) + AW'(HDR);
          prev_size_nxt = rd_size;
          prev_used_nxt = rd_used;
          idx_nxt       = idx_r + NW'(1);
          state_nxt     = S_SCAN_RD;
        end
      end

      S_FREE_SET: begin
        wa_idx_nxt  = p_free ? (hit_idx_r - NW'(1)) : hit_idx_r;
        wa_data_nxt = {1'b0, merged};
        two_wr_nxt  = 1'b0;
        up_nxt      = 1'b0;
        src_nxt     = cp_src;
        dst_nxt     = cp_src - shift_k;
        left_nxt    = (shift_k == '0) ? '0 : (count_r - cp_src);
        count_nxt   = count_r - shift_k;
        stat_nxt    = ST_OK;
        state_nxt   = S_COPY_RD;
      end

      S_COPY_RD: begin
        if (left_r == '0) begin
          state_nxt = S_WR_A;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = src_r[IW-1:0];
          state_nxt = S_COPY_WR;
        end
      end

      S_COPY_WR: begin
        wr_en    = 1'b1;
        wr_addr  = dst_r[IW-1:0];
        wr_data  = rd_data;
        left_nxt = left_r - NW'(1);
        if (up_r) begin
          src_nxt = src_r - NW'(1);
          dst_nxt = dst_r - NW'(1);
        end else begin
          src_nxt = src_r + NW'(1);
          dst_nxt = dst_r + NW'(1);
        end
        state_nxt = S_COPY_RD;
      end

      S_WR_A: begin
        wr_en     = 1'b1;
        wr_addr   = wa_idx_r[IW-1:0];
        wr_data   = wa_data_r;
        state_nxt = two_wr_r ? S_WR_B : S_RESP;
      end

      S_WR_B: begin
        wr_en     = 1'b1;
        wr_addr   = wb_idx_r[IW-1:0];
        wr_data   = wb_data_r;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.status          = stat_r;
          out_data_nxt.payload_address = (stat_r == ST_OK) ? res_addr_r : 16'd0;
          state_nxt                    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/ffsa_check.sv -----
// ----------------------------------------------------------------------------
// ffsa_check: port-level checks for the first-fit segment allocator
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module ffsa_check
  import ffsa_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input ffsa_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input ffsa_out_t out_data
);

  // a stalled response word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("response changed while stalled");

  // reset empties the response register and blocks requests for the seed cycle
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("response or ready active after reset");

  // one request in flight: busy right after accepting a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // failed requests never report an address
  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.payload_address == 16'd0)
    else $error("failed request reported an address");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ST_OK || out_data.status == ST_NO_SPACE ||
                  out_data.status == ST_BAD_FREE)
    else $error("undefined status code");

endmodule

bind first_fit_segment_allocator_top ffsa_check u_ffsa_check (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the first-fit segment allocator
// Drives allocate and free words with random gaps and receiver stalls. A
// segment-table predictor in the bench works out every reply at the moment
// its request word is taken, and a checker compares the replies in order.
// ----------------------------------------------------------------------------
module tb_top
  import ffsa_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP     = HEAP_BYTES_DEF;
  localparam int HDR      = HEADER_BYTES_DEF;
  localparam int MAX_SEG  = MAX_SEGMENTS_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_SHOWN   = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  ffsa_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ffsa_out_t out_data;

  first_fit_segment_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5ns clk = ~clk;

  // Segment table as the bench sees it
  int seg_bytes [MAX_SEG];
  bit seg_busy  [MAX_SEG];
  int live_segs;

  ffsa_out_t pending_replies [$];
  int  mismatch_count = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;
  int  rx_hold_cycles = 0;
  int  quiet_cycles = 0;

  function automatic void clear_table();
    for (int k = 0; k < MAX_SEG; k++) begin
      seg_bytes[k] = 0;
      seg_busy[k]  = 1'b0;
    end
    seg_bytes[0] = HEAP - HDR;
    live_segs    = 1;
  endfunction

  function automatic void drop_segment(int k);
    for (int i = k; i + 1 < live_segs; i++) begin
      seg_bytes[i] = seg_bytes[i + 1];
      seg_busy[i]  = seg_busy[i + 1];
    end
    live_segs--;
    seg_bytes[live_segs] = 0;
    seg_busy[live_segs]  = 1'b0;
  endfunction

  function automatic ffsa_out_t alloc_outcome(int req);
    ffsa_out_t r;
    int addr;
    int hit;
    r.status          = ST_NO_SPACE;
    r.payload_address = '0;
    addr = 0;
    hit  = -1;
    if (req == 0) return r;
    for (int k = 0; k < live_segs && hit < 0; k++) begin
      addr += HDR;
      if (!seg_busy[k] && seg_bytes[k] >= req) hit = k;
      else addr += seg_bytes[k];
    end
    if (hit < 0) return r;
    // only the first candidate counts: no fit and no room to split -> fail
    if (seg_bytes[hit] == req) begin
      seg_busy[hit] = 1'b1;
    end else if (seg_bytes[hit] >= req + HDR) begin
      if (live_segs >= MAX_SEG) return r;
      for (int j = live_segs; j > hit + 1; j--) begin
        seg_bytes[j] = seg_bytes[j - 1];
        seg_busy[j]  = seg_busy[j - 1];
      end
      seg_bytes[hit + 1] = seg_bytes[hit] - req - HDR;
      seg_busy[hit + 1]  = 1'b0;
      seg_bytes[hit]     = req;
      seg_busy[hit]      = 1'b1;
      live_segs++;
    end else begin
      return r;
    end
    r.status          = ST_OK;
    r.payload_address = 16'(addr);
    return r;
  endfunction

  function automatic ffsa_out_t free_outcome(logic [15:0] where);
    ffsa_out_t r;
    int addr;
    int hit;
    r.status          = ST_BAD_FREE;
    r.payload_address = '0;
    addr = 0;
    hit  = -1;
    for (int k = 0; k < live_segs && hit < 0; k++) begin
      addr += HDR;
      if (seg_busy[k] && (addr & 32'hFFFF) == int'(where)) hit = k;
      else addr += seg_bytes[k];
    end
    if (hit < 0) return r;
    seg_busy[hit] = 1'b0;
    if (hit + 1 < live_segs && !seg_busy[hit + 1]) begin
      seg_bytes[hit] += seg_bytes[hit + 1] + HDR;
      drop_segment(hit + 1);
    end
    if (hit > 0 && !seg_busy[hit - 1]) begin
      seg_bytes[hit - 1] += seg_bytes[hit] + HDR;
      drop_segment(hit);
    end
    r.status = ST_OK;
    return r;
  endfunction

  // payload address of a random segment, -1 if none qualifies
  function automatic int pick_segment_addr(bit busy_only);
    int n;
    int sel;
    int addr;
    n = 0;
    for (int k = 0; k < live_segs; k++)
      if (!busy_only || seg_busy[k]) n++;
    if (n == 0) return -1;
    sel  = $urandom_range(n - 1, 0);
    addr = 0;
    for (int k = 0; k < live_segs; k++) begin
      addr += HDR;
      if (!busy_only || seg_busy[k]) begin
        if (sel == 0) return addr;
        sel--;
      end
      addr += seg_bytes[k];
    end
    return -1;
  endfunction

  function automatic ffsa_in_t alloc_word(int n);
    ffsa_in_t w;
    w.action        = ACT_ALLOC;
    w.request_bytes = 16'(n);
    w.free_address  = 16'($urandom);
    return w;
  endfunction

  function automatic ffsa_in_t free_word(int a);
    ffsa_in_t w;
    w.action        = ACT_FREE;
    w.request_bytes = 16'($urandom);
    w.free_address  = 16'(a);
    return w;
  endfunction

  // Offer one word, book its reply when taken, then idle for a random gap
  task automatic send_word(ffsa_in_t w);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (w.action == ACT_ALLOC) pending_replies.push_back(alloc_outcome(int'(w.request_bytes)));
    else pending_replies.push_back(free_outcome(w.free_address));
    gap = tx_idle_en ? $urandom_range(13, 0) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, ffsa_out_t want, ffsa_out_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN)
      $display("%0t: %s: expected status %0d addr %0d, got status %0d addr %0d",
               $realtime, what, want.status, want.payload_address,
               got.status, got.payload_address);
  endtask

  // Receiver: random stall per word, plus a long hold-off on request
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if (rx_hold_cycles > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (rx_hold_cycles - 1) @(negedge clk);
        rx_hold_cycles = 0;
      end
      stall = rx_idle_en ? $urandom_range(13, 0) : 0;
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    ffsa_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with nothing pending", '0, out_data);
      end else begin
        want = pending_replies.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", want, out_data);
        else if (out_data.payload_address !== want.payload_address)
          report_mismatch("payload_address", want, out_data);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, %0d replies pending", $realtime, pending_replies.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---- tests ----

  task automatic test_fresh_heap();
    send_word(alloc_word(0));            // zero request
    send_word(alloc_word(32768));        // as large as the heap
    send_word(alloc_word(HEAP - HDR));   // exact fit of the whole heap
    send_word(alloc_word(1));            // nothing left
    send_word(free_word(HDR));
    send_word(free_word(HDR));           // double free
    send_word(free_word(0));
    send_word(free_word(32768));
    send_word(free_word(16'h7FFF));
  endtask

  task automatic test_split_and_merge();
    send_word(alloc_word(100));          // 24
    send_word(alloc_word(100));          // 148
    send_word(alloc_word(100));          // 272
    send_word(free_word(148));
    // first free hole is too small to split for 90, later space is not tried
    send_word(alloc_word(90));
    send_word(free_word(24));            // merges with free successor
    send_word(free_word(272));           // merges both sides and the tail
    send_word(alloc_word(32767));
    send_word(alloc_word(HEAP - HDR));
    send_word(free_word(HDR));
  endtask

  task automatic test_table_full();
    for (int k = 0; k < MAX_SEG - 1; k++) send_word(alloc_word(8));
    send_word(alloc_word(8));            // split needed, table is full
    send_word(alloc_word(HEAP - HDR - (MAX_SEG - 1) * (8 + HDR)));
    send_word(alloc_word(1));            // last segment is taken
    for (int k = 1; k < MAX_SEG; k += 2) send_word(free_word(HDR + k * (8 + HDR)));
    for (int k = 0; k < MAX_SEG; k += 2) send_word(free_word(HDR + k * (8 + HDR)));
  endtask

  task automatic test_backpressure();
    rx_hold_cycles = 400;
    for (int k = 0; k < 12; k++) begin
      if (k % 3 == 2) send_word(free_word(pick_segment_addr(1'b0)));
      else send_word(alloc_word($urandom_range(200, 1)));
    end
  endtask

  task automatic test_random(int items, int max_req);
    int roll;
    int a;
    for (int n = 0; n < items; n++) begin
      roll = $urandom_range(99, 0);
      if (roll < 50) begin
        if (roll < 2) send_word(alloc_word(0));
        else if (roll < 6) send_word(alloc_word($urandom_range(32768, 1)));
        else send_word(alloc_word($urandom_range(max_req, 1)));
      end else if (roll < 90) begin
        a = pick_segment_addr(1'b1);
        if (a < 0) a = $urandom_range(32768, 0);
        send_word(free_word(a));
      end else begin
        // junk: free of a hole or of a random offset
        a = (roll < 95) ? pick_segment_addr(1'b0) : -1;
        if (a < 0) a = $urandom_range(32768, 0);
        send_word(free_word(a));
      end
    end
  endtask

  initial begin
    clear_table();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_fresh_heap();
    test_split_and_merge();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_table_full();
    test_backpressure();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_random(240, 64);
    tx_idle_en = 1'b0;
    test_random(300, 1500);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b0;
    test_random(300, 600);
    rx_idle_en = 1'b1;
    test_random(200, 4000);

    wait_drain();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
